// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define DCD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset
`define DCD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hdl/dcd_pkg.sv -----
// Package of the dependency cycle detector: sizes, derived widths, FSM states.
// No dependencies; used by the top level and the testbench.
`timescale 1ns / 1ps
package dcd_pkg;

	localparam int MAX_NODES = 64;
	localparam int MAX_EDGES = 256;

	localparam int NODE_W  = $clog2(MAX_NODES);      // node index
	localparam int CNT_W   = $clog2(MAX_NODES + 1);  // node count, queue pointers
	localparam int EDGE_AW = $clog2(MAX_EDGES);      // edge store address
	localparam int EDGE_CW = $clog2(MAX_EDGES + 1);  // edge count
	localparam int DEG_W   = $clog2(MAX_EDGES + 1);  // in-degree value
	localparam int EDGE_DW = 2 * NODE_W;             // stored {from, to}
	localparam int CFG_W   = 7;                      // node_count register

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_FETCH,
		ST_FETCH_WAIT,
		ST_WALK,
		ST_RESULT
	} dcd_state_t;

endpackage

// ----- hdl/dependency_cycle_detector.sv -----
// Top level of the dependency cycle detector: edge loading and Kahn evaluation.
// Depends on dcd_pkg and dcd_ram (in-degree store, edge store, ready queue).
`timescale 1ns / 1ps
//
// Channel   Handshake            Payload
// --------  -------------------  ------------------------------------------
// input     start & !busy        edge_present, edge_from, edge_to, last_edge
// result    done (one cycle)     has_cycle, edge_error
// config    cfg_we               cfg_wdata (node_count)
//
// Each input beat is an in-degree read, then the write back.
// On a last beat the evaluation follows: a scan of the N nodes, then for each
// ordered node a queue fetch plus a walk over the E stored edges (none when
// no edge is stored), then a closing fetch and the result cycle; busy stays
// high throughout.
// Reset clears all control state and the in-degree valid bits; no clearing pass.
// The receiver cannot stall: done is high for exactly one cycle per result.
module dependency_cycle_detector (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      edge_present,
	input  logic [dcd_pkg::NODE_W-1:0] edge_from,
	input  logic [dcd_pkg::NODE_W-1:0] edge_to,
	input  logic                      last_edge,
	input  logic                      cfg_we,
	input  logic [dcd_pkg::CFG_W-1:0] cfg_wdata,
	output logic                      done,
	output logic                      has_cycle,
	output logic                      edge_error
);

	import dcd_pkg::*;

	dcd_state_t state_q, state_d;

	// control registers
	logic [CFG_W-1:0]   node_count_q;
	logic [EDGE_CW-1:0] edge_total_q;
	logic               err_q;
	logic [CNT_W-1:0]   v_q, head_q, tail_q;
	logic [EDGE_CW-1:0] e_q;
	logic               ld_ok_q, ld_last_q;
	logic               scan_vld_s1, walk_vld_s1, dec_vld_s2;
	logic               fwd_vld_q;
	logic [MAX_NODES-1:0] indeg_vld_q;

	// payload registers
	logic [NODE_W-1:0] ld_from_q, ld_to_q, cur_q;
	logic [NODE_W-1:0] scan_node_s1, dec_node_s2, fwd_addr_q;
	logic [DEG_W-1:0]  fwd_data_q;

	// memory ports
	logic               indeg_we;
	logic [NODE_W-1:0]  indeg_waddr, indeg_raddr;
	logic [DEG_W-1:0]   indeg_wdata, indeg_rdata;
	logic               edge_we;
	logic [EDGE_DW-1:0] edge_rdata;
	logic               queue_we;
	logic [NODE_W-1:0]  queue_wdata, queue_rdata;

	// decoded control
	logic             accept;
	logic             scan_issue, walk_issue, fetch_issue;
	logic [CFG_W-1:0] nodes;
	logic             item_ok;
	logic [DEG_W-1:0] ld_old, dec_old;
	logic             scan_zero, walk_match, dec_we;
	logic             scan_push, dec_push;

	assign accept = start && !busy;
	assign nodes  = (node_count_q > CFG_W'(MAX_NODES)) ? CFG_W'(MAX_NODES) : node_count_q;

	// check an incoming edge against the nodes in use and the store size
	assign item_ok = edge_present
		&& (CFG_W'(edge_from) < nodes) && (CFG_W'(edge_to) < nodes)
		&& (edge_total_q < EDGE_CW'(MAX_EDGES));

	// in-degree reads: an entry not yet written this graph reads as zero
	assign ld_old    = indeg_vld_q[ld_to_q] ? indeg_rdata : '0;
	assign scan_zero = !indeg_vld_q[scan_node_s1] || (indeg_rdata == '0);
	always_comb begin
		if (fwd_vld_q && (fwd_addr_q == dec_node_s2)) begin
			dec_old = fwd_data_q;
		end else if (indeg_vld_q[dec_node_s2]) begin
			dec_old = indeg_rdata;
		end else begin
			dec_old = '0;
		end
	end

	assign walk_match = walk_vld_s1 && (edge_rdata[EDGE_DW-1:NODE_W] == cur_q);
	assign dec_we     = dec_vld_s2 && (dec_old != '0);
	assign dec_push   = dec_we && (dec_old == DEG_W'(1)) && (CFG_W'(dec_node_s2) < nodes);
	assign scan_push  = scan_vld_s1 && scan_zero;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       if (accept) state_d = ST_LOAD;
			ST_LOAD:       state_d = ld_last_q ? ST_SCAN : ST_IDLE;
			ST_SCAN:       if (CFG_W'(v_q + CNT_W'(1)) >= nodes) state_d = ST_DRAIN;
			ST_DRAIN: begin
				if (!scan_vld_s1 && !walk_vld_s1 && !dec_vld_s2) state_d = ST_FETCH;
			end
			ST_FETCH:      state_d = (head_q < tail_q) ? ST_FETCH_WAIT : ST_RESULT;
			ST_FETCH_WAIT: state_d = (edge_total_q == '0) ? ST_FETCH : ST_WALK;
			ST_WALK:       if (e_q + EDGE_CW'(1) == edge_total_q) state_d = ST_DRAIN;
			ST_RESULT:     state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy        = (state_q != ST_IDLE);
		done        = (state_q == ST_RESULT);
		scan_issue  = (state_q == ST_SCAN) && (CFG_W'(v_q) < nodes);
		walk_issue  = (state_q == ST_WALK);
		fetch_issue = (state_q == ST_FETCH) && (head_q < tail_q);
	end

	assign has_cycle  = (CFG_W'(tail_q) != nodes);
	assign edge_error = err_q;

	// in-degree port: load write back or walk decrement; read address by phase
	always_comb begin
		indeg_we    = 1'b0;
		indeg_waddr = dec_node_s2;
		indeg_wdata = dec_old - DEG_W'(1);
		if (state_q == ST_LOAD) begin
			indeg_we    = ld_ok_q;
			indeg_waddr = ld_to_q;
			indeg_wdata = ld_old + DEG_W'(1);
		end else if (dec_we) begin
			indeg_we = 1'b1;
		end
		unique case (state_q)
			ST_IDLE: indeg_raddr = edge_to;
			ST_SCAN: indeg_raddr = v_q[NODE_W-1:0];
			default: indeg_raddr = edge_rdata[NODE_W-1:0];
		endcase
	end

	assign edge_we     = (state_q == ST_LOAD) && ld_ok_q;
	assign queue_we    = scan_push || dec_push;
	assign queue_wdata = scan_push ? scan_node_s1 : dec_node_s2;

	dcd_ram #(.DEPTH(MAX_NODES), .WIDTH(DEG_W)) u_indeg (
		.clk   (clk),
		.we    (indeg_we),
		.waddr (indeg_waddr),
		.wdata (indeg_wdata),
		.raddr (indeg_raddr),
		.rdata (indeg_rdata)
	);

	dcd_ram #(.DEPTH(MAX_EDGES), .WIDTH(EDGE_DW)) u_edges (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_total_q[EDGE_AW-1:0]),
		.wdata ({ld_from_q, ld_to_q}),
		.raddr (e_q[EDGE_AW-1:0]),
		.rdata (edge_rdata)
	);

	dcd_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_queue (
		.clk   (clk),
		.we    (queue_we),
		.waddr (tail_q[NODE_W-1:0]),
		.wdata (queue_wdata),
		.raddr (head_q[NODE_W-1:0]),
		.rdata (queue_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= '0;
			edge_total_q <= '0;
			err_q        <= 1'b0;
			v_q          <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			e_q          <= '0;
			ld_ok_q      <= 1'b0;
			ld_last_q    <= 1'b0;
			scan_vld_s1  <= 1'b0;
			walk_vld_s1  <= 1'b0;
			dec_vld_s2   <= 1'b0;
			fwd_vld_q    <= 1'b0;
			indeg_vld_q  <= '0;
		end else begin
			state_q     <= state_d;
			scan_vld_s1 <= scan_issue;
			walk_vld_s1 <= walk_issue;
			dec_vld_s2  <= walk_match;
			fwd_vld_q   <= dec_we;

			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end

			// latch the beat; flag a dropped edge
			if (accept) begin
				ld_ok_q   <= item_ok;
				ld_last_q <= last_edge;
				if (edge_present && !item_ok) begin
					err_q <= 1'b1;
				end
			end

			if (edge_we) begin
				edge_total_q <= edge_total_q + EDGE_CW'(1);
			end
			if (indeg_we) begin
				indeg_vld_q[indeg_waddr] <= 1'b1;
			end

			// advance the walk pointers
			if (scan_issue) begin
				v_q <= v_q + CNT_W'(1);
			end
			if (queue_we) begin
				tail_q <= tail_q + CNT_W'(1);
			end
			if (fetch_issue) begin
				head_q <= head_q + CNT_W'(1);
			end
			if (state_q == ST_FETCH_WAIT) begin
				e_q <= '0;
			end else if (walk_issue) begin
				e_q <= e_q + EDGE_CW'(1);
			end

			// drop the graph after its result
			if (state_q == ST_RESULT) begin
				edge_total_q <= '0;
				err_q        <= 1'b0;
				v_q          <= '0;
				head_q       <= '0;
				tail_q       <= '0;
				indeg_vld_q  <= '0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ld_from_q <= edge_from;
			ld_to_q   <= edge_to;
		end
		if (state_q == ST_FETCH_WAIT) begin
			cur_q <= queue_rdata;
		end
		scan_node_s1 <= v_q[NODE_W-1:0];
		dec_node_s2  <= edge_rdata[NODE_W-1:0];
		fwd_addr_q   <= dec_node_s2;
		fwd_data_q   <= indeg_wdata;
	end

endmodule

// ----- hdl/dcd_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// No dependencies; sized by its parameters.
`timescale 1ns / 1ps
module dcd_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then registered read (old data on a same-address clash)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/dcd_checker.sv -----
// Port-level checker for the dependency cycle detector, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dcd_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic last_edge,
	input logic done
);

	// an accepted beat always holds the block for its load cycle
	`DCD_ASSERT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy, "busy low after a beat")
	// a beat that does not close the graph frees the block after its load cycle
	`DCD_ASSERT(a_plain_beat, clk, arst_n, start && !busy && !last_edge |=> ##1 !busy, "long beat")
	// a result beat lasts one cycle and ends the evaluation
	`DCD_ASSERT(a_done_pulse, clk, arst_n, done |=> (!done && !busy), "result strobe held")
	// no result while idle
	`DCD_ASSERT_NEVER(a_done_idle, clk, arst_n, done && !busy, "result while idle")

endmodule

bind dependency_cycle_detector dcd_checker u_dcd_checker (.*);

// ----- tb/sv/dependency_cycle_detector_tb.sv -----
// Self-checking testbench of dependency_cycle_detector: directed graphs, then random ones.
// Depends on dcd_pkg and the RTL top level; a scoreboard class predicts each cycle verdict.
`timescale 1ns / 1ps
module dependency_cycle_detector_tb;
	import dcd_pkg::*;

	localparam int ITEM_BUDGET   = 1650;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 64;
	localparam int LIMIT_CYCLES  = 2_000_000;
	localparam int PRINT_CAP     = 100;
	localparam int MAX_ID        = MAX_NODES - 1;
	localparam int MAX_CFG       = (1 << CFG_W) - 1;
	localparam int ARC_CAP       = 24;

	typedef struct packed {
		logic has_cycle;
		logic edge_error;
	} verdict_t;

	typedef enum int {KIND_DAG, KIND_ANY, KIND_NOISE, KIND_SPARSE} graph_kind_t;

	// Kahn sort predictor plus the queue of verdicts still owed by the block
	class graph_scoreboard;
		bit [CFG_W-1:0]   node_count;
		bit [DEG_W-1:0]   in_deg [MAX_NODES];
		bit [EDGE_DW-1:0] arc_mem [MAX_EDGES];
		int unsigned      arc_cnt;
		bit               drop_seen;
		verdict_t         verdict_q [$];
		int unsigned      mismatches;

		function new();
			node_count = '0;
			arc_cnt    = 0;
			drop_seen  = 1'b0;
			mismatches = 0;
			foreach (in_deg[i]) in_deg[i] = '0;
		endfunction

		function int unsigned live_nodes();
			return (node_count > MAX_NODES) ? MAX_NODES : node_count;
		endfunction

		// Peel zero in-degree nodes until none is left; return how many got ordered
		function int unsigned count_ordered(int unsigned n);
			bit [NODE_W-1:0] ready [$];
			bit [NODE_W-1:0] cur, src, dst;
			int unsigned     ordered;
			ordered = 0;
			for (int nd = 0; nd < n; nd++) begin
				if (in_deg[nd] == 0) begin
					ready = {ready, NODE_W'(nd)};
					ordered++;
				end
			end
			while (ready.size() != 0) begin
				cur = ready.pop_front();
				for (int e = 0; e < arc_cnt; e++) begin
					{src, dst} = arc_mem[e];
					if (src == cur && in_deg[dst] != 0) begin
						in_deg[dst]--;
						// successors outside the live range drop but never order
						if (in_deg[dst] == 0 && dst < n) begin
							ready = {ready, dst};
							ordered++;
						end
					end
				end
			end
			return ordered;
		endfunction

		// Note one accepted input beat
		function void load_beat(logic present, logic [NODE_W-1:0] src,
				logic [NODE_W-1:0] dst, logic closing);
			int unsigned n;
			verdict_t    exp;
			n = live_nodes();
			if (present) begin
				if (src >= n || dst >= n || arc_cnt >= MAX_EDGES) begin
					drop_seen = 1'b1;
				end else begin
					arc_mem[arc_cnt] = {src, dst};
					arc_cnt++;
					in_deg[dst]++;
				end
			end
			if (closing) begin
				exp.has_cycle  = (count_ordered(n) != n);
				exp.edge_error = drop_seen;
				verdict_q = {verdict_q, exp};
				foreach (in_deg[i]) in_deg[i] = '0;
				arc_cnt   = 0;
				drop_seen = 1'b0;
			end
		endfunction

		task report(string what);
			if (mismatches < PRINT_CAP) $display("[%0t] MISMATCH %s", $time, what);
			mismatches++;
		endtask

		// Compare one result beat with the oldest owed verdict
		task check_verdict(logic hc, logic ee);
			verdict_t exp;
			if (verdict_q.size() == 0) begin
				report($sformatf("result with none owed: has_cycle=%0b edge_error=%0b", hc, ee));
			end else begin
				exp = verdict_q.pop_front();
				if (hc !== exp.has_cycle)
					report($sformatf("has_cycle got %0b want %0b", hc, exp.has_cycle));
				if (ee !== exp.edge_error)
					report($sformatf("edge_error got %0b want %0b", ee, exp.edge_error));
			end
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              edge_present;
	logic [NODE_W-1:0] edge_from;
	logic [NODE_W-1:0] edge_to;
	logic              last_edge;
	logic              cfg_we;
	logic [CFG_W-1:0]  cfg_wdata;
	logic              done;
	logic              has_cycle;
	logic              edge_error;

	graph_scoreboard sb;
	int unsigned     burst_left;
	int unsigned     sent;
	int unsigned     live;
	int unsigned     perm [MAX_NODES];

	dependency_cycle_detector u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.edge_present (edge_present),
		.edge_from    (edge_from),
		.edge_to      (edge_to),
		.last_edge    (last_edge),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.has_cycle    (has_cycle),
		.edge_error   (edge_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up on a hung run
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	// Track accepted input beats and register writes
	always @(posedge clk) begin
		if (arst_n && start && !busy) sb.load_beat(edge_present, edge_from, edge_to, last_edge);
		if (arst_n && cfg_we) sb.node_count = cfg_wdata;
	end

	// Check every result beat
	always @(posedge clk) begin
		if (arst_n && done) sb.check_verdict(has_cycle, edge_error);
	end

	// Drive one input beat, with a random gap at the head of each burst
	task automatic put_beat(input logic p, input logic [NODE_W-1:0] f,
			input logic [NODE_W-1:0] t, input logic l, input bit bursty);
		int unsigned gap;
		if (bursty && burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				@(negedge clk) start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		if (burst_left != 0) burst_left--;
		@(negedge clk);
		start        <= 1'b1;
		edge_present <= p;
		edge_from    <= f;
		edge_to      <= t;
		last_edge    <= l;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	// Drop start and wait until no verdict is owed and any load has finished
	task automatic hold_until_drained();
		@(negedge clk) start <= 1'b0;
		while (sb.verdict_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_node_count(input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= val;
		@(negedge clk) cfg_we <= 1'b0;
		live = (val > MAX_NODES) ? MAX_NODES : val;
	endtask

	function automatic logic [CFG_W-1:0] pick_node_count();
		unique case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return 2;
			3: return CFG_W'(MAX_NODES);
			4: return CFG_W'($urandom_range(MAX_NODES + 1, MAX_CFG));
			default: return CFG_W'($urandom_range(3, 16));
		endcase
	endfunction

	// Shuffle the first n node ids so that a DAG follows a random order
	task automatic shuffle_nodes(input int unsigned n);
		int unsigned k, j, tmp;
		for (k = 0; k < MAX_NODES; k++) perm[k] = k;
		for (k = n; k > 1; k--) begin
			j           = $urandom_range(0, k - 1);
			tmp         = perm[k - 1];
			perm[k - 1] = perm[j];
			perm[j]     = tmp;
		end
	endtask

	// Send one graph; optionally change the node count halfway through
	task automatic send_graph(input int unsigned n_arcs, input graph_kind_t kind,
			input bit reshape);
		int unsigned       i, j, k, n;
		logic [NODE_W-1:0] f, t;
		logic              p;
		bit                arc_on_close;
		bit                is_close;
		n = live;
		shuffle_nodes(n);
		arc_on_close = (n_arcs != 0) && ($urandom_range(0, 1) == 1);
		for (k = 0; k < n_arcs; k++) begin
			if (reshape && k == n_arcs / 2) begin
				hold_until_drained();
				program_node_count(pick_node_count());
				n = live;
				shuffle_nodes(n);
			end
			is_close = arc_on_close && (k == n_arcs - 1);
			p = 1'b1;
			if (kind == KIND_SPARSE && !is_close && $urandom_range(0, 3) == 0) p = 1'b0;
			if ((kind == KIND_NOISE && $urandom_range(0, 2) == 0) || n == 0 ||
					(kind == KIND_DAG && n < 2)) begin
				f = NODE_W'($urandom_range(0, MAX_ID));
				t = NODE_W'($urandom_range(0, MAX_ID));
			end else if (kind == KIND_DAG) begin
				i = $urandom_range(0, n - 2);
				j = $urandom_range(i + 1, n - 1);
				f = NODE_W'(perm[i]);
				t = NODE_W'(perm[j]);
			end else begin
				f = NODE_W'($urandom_range(0, n - 1));
				t = NODE_W'($urandom_range(0, n - 1));
			end
			put_beat(p, f, t, is_close, 1'b1);
		end
		// close with a bare marker when the last arc did not
		if (!arc_on_close)
			put_beat(1'b0, NODE_W'($urandom_range(0, MAX_ID)),
				NODE_W'($urandom_range(0, MAX_ID)), 1'b1, 1'b1);
	endtask

	initial begin
		int unsigned graph_no;
		int unsigned n_arcs;
		int unsigned r;
		graph_kind_t kind;

		arst_n       = 1'b0;
		start        = 1'b0;
		edge_present = 1'b0;
		edge_from    = '0;
		edge_to      = '0;
		last_edge    = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		sb           = new();
		burst_left   = 0;
		sent         = 0;
		live         = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty graph, then an edge with no node in use
		program_node_count(0);
		put_beat(1'b0, 0, 0, 1'b1, 1'b0);
		put_beat(1'b1, 0, 0, 1'b1, 1'b0);
		hold_until_drained();
		program_node_count(4);
		// chain closed by an edge on the last beat
		put_beat(1'b1, 0, 1, 1'b0, 1'b0);
		put_beat(1'b1, 1, 2, 1'b0, 1'b0);
		put_beat(1'b1, 2, 3, 1'b1, 1'b0);
		// two-node cycle, then a self loop
		put_beat(1'b1, 0, 1, 1'b0, 1'b0);
		put_beat(1'b1, 1, 0, 1'b0, 1'b0);
		put_beat(1'b0, 0, 0, 1'b1, 1'b0);
		put_beat(1'b1, 3, 3, 1'b1, 1'b0);
		// bad source, then an ignored beat and a bad target at the top id
		put_beat(1'b1, 1, 2, 1'b0, 1'b0);
		put_beat(1'b1, 5, 0, 1'b0, 1'b0);
		put_beat(1'b0, 0, 0, 1'b1, 1'b0);
		put_beat(1'b0, NODE_W'(MAX_ID), NODE_W'(MAX_ID), 1'b0, 1'b0);
		put_beat(1'b1, 0, NODE_W'(MAX_ID), 1'b1, 1'b0);
		// node count above capacity: cycle across the extreme ids
		hold_until_drained();
		program_node_count(CFG_W'(MAX_CFG));
		put_beat(1'b1, NODE_W'(MAX_ID), 0, 1'b0, 1'b0);
		put_beat(1'b1, 0, NODE_W'(MAX_ID), 1'b1, 1'b0);
		put_beat(1'b1, NODE_W'(MAX_ID), NODE_W'(MAX_ID - 1), 1'b1, 1'b0);
		// shrink the node count mid graph: the cycle on 6/7 falls out of range
		hold_until_drained();
		program_node_count(8);
		put_beat(1'b1, 6, 7, 1'b0, 1'b0);
		put_beat(1'b1, 7, 6, 1'b0, 1'b0);
		put_beat(1'b1, 0, 1, 1'b0, 1'b0);
		put_beat(1'b1, 1, 5, 1'b0, 1'b0);
		hold_until_drained();
		program_node_count(4);
		put_beat(1'b0, 0, 0, 1'b1, 1'b0);

		// Random graphs, two of them large enough to overflow the edge store
		graph_no = 0;
		while (sent < ITEM_BUDGET) begin
			if (graph_no == 25 || graph_no == 90) begin
				hold_until_drained();
				program_node_count(CFG_W'(MAX_NODES));
				send_graph($urandom_range(MAX_EDGES + 1, MAX_EDGES + 6), KIND_DAG, 1'b0);
			end else begin
				if (graph_no % 10 == 0) begin
					hold_until_drained();
					program_node_count(pick_node_count());
				end else if ($urandom_range(0, 5) == 0) begin
					hold_until_drained();
				end
				if (live == 0) n_arcs = $urandom_range(0, 3);
				else n_arcs = $urandom_range(0, (2 * live + 2 > ARC_CAP) ? ARC_CAP : 2 * live + 2);
				r = $urandom_range(0, 9);
				kind = (r < 5) ? KIND_DAG : (r < 7) ? KIND_ANY : (r < 9) ? KIND_NOISE : KIND_SPARSE;
				send_graph(n_arcs, kind, $urandom_range(0, 7) == 0);
			end
			graph_no++;
		end

		// Drain, let the tail settle, then judge
		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.verdict_q.size() != 0)
			sb.report($sformatf("%0d verdicts never arrived", sb.verdict_q.size()));
		if (sb.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/dcd_pkg.sv
hdl/dcd_ram.sv
hdl/dependency_cycle_detector.sv
hdl/dcd_checker.sv
tb/sv/dependency_cycle_detector_tb.sv
